// File: rtl/core/mmdf_pkg.sv
// Shared types and defaults for the moving mean difference filter.
`timescale 1ns / 1ps

package mmdf_pkg;

  localparam int WINDOW_LEN_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 20;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PREP,
    ST_DIVIDE,
    ST_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // latch sample, read oldest ring entry
    logic update;    // update sum, write ring, advance pointers
    logic prep;      // load divider with |sum| and the fill count
    logic div_step;  // one restoring division step
    logic out_load;  // form the difference into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // output register can take a new result this cycle
  } dp_status_t;

endpackage

// File: rtl/core/mmdf_stream_if.sv
// Valid/ready stream interfaces for sample requests and difference results.
`timescale 1ns / 1ps

interface mmdf_sample_if
  import mmdf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mmdf_diff_if
  import mmdf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] difference;

  modport source (output valid, output difference, input ready);
  modport sink   (input valid, input difference, output ready);
endinterface

// File: rtl/core/mmdf_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mmdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mmdf_ctrl.sv
// Controller state machine: sequences update, divide and output load.
`timescale 1ns / 1ps

module mmdf_ctrl
  import mmdf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  localparam int STEP_W = $clog2(SAMPLE_BITS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SAMPLE_BITS - 1);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  // State and step counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        step_d     = '0;
        state_d    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait until the previous result has left the output register
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Division runs exactly SAMPLE_BITS steps
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE && step_q == LAST_STEP) |=> (state_q == ST_DONE))
    else $error("divider did not finish after the last step");

  a_prep_clears_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PREP) |=> (state_q == ST_DIVIDE && step_q == '0))
    else $error("division did not start from step zero");

  a_single_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (!in_ready_o && state_q == ST_UPDATE))
    else $error("new request taken while one is in flight");

endmodule

// File: rtl/core/mmdf_datapath.sv
// Datapath: sample ring, running sum, serial divider and output register.
`timescale 1ns / 1ps

module mmdf_datapath
  import mmdf_pkg::*;
#(
  parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dp_cmd_t                       cmd_i,
  output dp_status_t                    status_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS:0]   diff_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i
);

  localparam int PTR_W  = $clog2(WINDOW_LEN);
  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = SAMPLE_BITS + PTR_W + 1;
  localparam int MAG_W  = SUM_W - 1;
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int EXT_W  = SAMPLE_BITS + 2;
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW_LEN - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_LEN);

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic [PTR_W-1:0]              wpos_q;
  logic [CNT_W-1:0]              fill_q;
  logic                          neg_q;
  logic [CNT_W-1:0]              div_q;
  logic [CNT_W-1:0]              rem_q;
  logic [SAMPLE_BITS-1:0]        qd_q;
  logic signed [DIFF_W-1:0]      diff_q;
  logic                          out_valid_q;

  logic                          full;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic [SAMPLE_BITS-1:0]        oldest;
  logic signed [SUM_W-1:0]       sum_next;
  logic [SUM_W-1:0]              mag;
  logic [CNT_W:0]                trial;
  logic                          ge;
  logic [CNT_W:0]                trial_sub;
  logic signed [EXT_W-1:0]       quot_ext;
  logic signed [EXT_W-1:0]       avg_ext;
  logic signed [EXT_W-1:0]       diff_ext;

  // Sample ring
  mmdf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (wpos_q),
    .wdata_i (sample_q),
    .re_i    (cmd_i.accept),
    .raddr_i (wpos_q),
    .rdata_o (ram_rdata)
  );

  // Until the ring is full the write pointer sits on never-written entries,
  // which count as zero.
  assign full   = (fill_q == FULL_CNT);
  assign oldest = full ? ram_rdata : '0;

  assign sum_next = sum_q
                  - {{(SUM_W-SAMPLE_BITS){oldest[SAMPLE_BITS-1]}}, oldest}
                  + {{(SUM_W-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};

  // Magnitude of the sum for the unsigned divider
  assign mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  // Restoring division step
  assign trial     = {rem_q, qd_q[SAMPLE_BITS-1]};
  assign ge        = (trial >= {1'b0, div_q});
  assign trial_sub = trial - {1'b0, div_q};

  // Signed average minus sample
  assign quot_ext = {2'b00, qd_q};
  assign avg_ext  = neg_q ? -quot_ext : quot_ext;
  assign diff_ext = avg_ext - {{2{sample_q[SAMPLE_BITS-1]}}, sample_q};

  // Window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      wpos_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.update) begin
      sum_q  <= sum_next;
      wpos_q <= (wpos_q == LAST_POS) ? '0 : wpos_q + 1'b1;
      if (!full) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Sample latch and divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
    if (cmd_i.prep) begin
      neg_q <= sum_q[SUM_W-1];
      div_q <= fill_q;
      // upper magnitude bits are already below the divisor
      rem_q <= CNT_W'(mag[MAG_W-1:SAMPLE_BITS]);
      qd_q  <= mag[SAMPLE_BITS-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      qd_q  <= {qd_q[SAMPLE_BITS-2:0], ge};
    end
    if (cmd_i.out_load) begin
      diff_q <= diff_ext[DIFF_W-1:0];
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign diff_o            = diff_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_CNT)
    else $error("fill count beyond window length");

  a_wpos_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != FULL_CNT) |-> (CNT_W'(wpos_q) == fill_q))
    else $error("write pointer out of step with fill count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < div_q))
    else $error("partial remainder not below divisor");

endmodule

// File: rtl/core/moving_mean_difference_filter.sv
// Requests are processed one at a time: a new one is taken only after the
// previous result is loaded into the output register. The bit-serial restoring
// divider produces one quotient bit per cycle.
// A finished result waits in the output register while the next request runs.
// Reset (async, active low) clears the sum, write pointer and fill count;
// ring entries not yet written read as zero, so no clearing pass is needed.
`timescale 1ns / 1ps

module moving_mean_difference_filter
  import mmdf_pkg::*;
#(
  parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mmdf_sample_if.sink  sample_i,
  mmdf_diff_if.source  diff_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign sample_i.ready = in_ready;

  mmdf_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  mmdf_datapath #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (sample_i.sample),
    .diff_o      (diff_o.difference),
    .out_valid_o (diff_o.valid),
    .out_ready_i (diff_o.ready)
  );

endmodule
